FILE: sv/conv_pkg.sv
// conv_pkg: sizes, command codes, register indexes and state codes for conv2d_relu_clamp.
// Stands alone; imported by the top level and its checker.
package conv_pkg;

  localparam int IMG_WIDTH    = 32;
  localparam int IMG_HEIGHT   = 32;
  localparam int IMG_DEPTH    = 3;
  localparam int NUM_FILTERS  = 3;
  localparam int KERNEL_DIM   = 3;

  localparam int PLANE        = IMG_WIDTH * IMG_HEIGHT;
  localparam int PIX_ENTRIES  = PLANE * IMG_DEPTH;
  localparam int KAREA        = KERNEL_DIM * KERNEL_DIM;
  localparam int W_PER_FILTER = IMG_DEPTH * KAREA;
  localparam int W_ENTRIES    = NUM_FILTERS * W_PER_FILTER;
  localparam int CLAMP_MAX    = 255;

  localparam int PIX_AW  = $clog2(PIX_ENTRIES);
  localparam int W_AW    = (W_ENTRIES > 1) ? $clog2(W_ENTRIES) : 1;
  localparam int BIAS_AW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int KC_W    = $clog2(KERNEL_DIM + 1);
  localparam int DC_W    = $clog2(IMG_DEPTH + 1);
  localparam int R0_W    = 7;   // out_row (5 bits) times stride (2 bits)
  localparam int POS_W   = 10;  // signed tap coordinates and padded extents
  localparam int PROD_W  = 17;  // unsigned 8-bit pixel times signed 8-bit weight
  localparam int ACC_W   = 32;

  typedef enum logic [1:0] {
    CMD_WR_PIX  = 2'd0,
    CMD_WR_WGT  = 2'd1,
    CMD_WR_BIAS = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_STRIDE  = 2'd0;
  localparam logic [1:0] REG_PADDING = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_RUN   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

endpackage

FILE: sv/conv2d_relu_clamp.sv
// conv2d_relu_clamp: one output pixel of a zero-padded 2-D convolution with ReLU clamp.
// Holds pixel, weight and bias memories; uses conv_pkg.
// Timing: write beats leave busy low. A compute beat raises busy, and done follows once all
//   IMG_DEPTH*KERNEL_DIM*KERNEL_DIM taps are accumulated and the pipeline has drained, or
//   straight from the range check when the request is out of range; no beat is taken while busy.
// Sequence: range check, then one tap read per cycle from the weight memory (and from the pixel
//   memory for taps inside the image), then drain of the multiply and accumulate registers.
// Reset: clears control state and sets stride and padding to 1; memories are not cleared.
module conv2d_relu_clamp
  import conv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [11:0]        addr,
  input  logic signed [15:0] data,
  input  logic [1:0]         filter_sel,
  input  logic [4:0]         out_row,
  input  logic [4:0]         out_col,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data,
  output logic               done,
  output logic [7:0]         pixel_out,
  output logic               out_of_range
);

  state_t state;

  logic [1:0] stride;
  logic [1:0] padding;

  logic [7:0]         pixel_mem [PIX_ENTRIES];
  logic [7:0]         weight_mem [W_ENTRIES];
  logic signed [15:0] bias_mem [NUM_FILTERS];

  logic [1:0]       fsel;
  logic [R0_W-1:0]  r0;
  logic [R0_W-1:0]  c0;
  logic [POS_W-1:0] rbase;
  logic [POS_W-1:0] cbase;
  logic [DC_W-1:0]  d_cnt;
  logic [KC_W-1:0]  m_cnt;
  logic [KC_W-1:0]  n_cnt;
  logic [W_AW-1:0]  w_addr;

  logic                     s1_valid;
  logic                     s1_ok;
  logic                     s2_valid;
  logic [7:0]               pix_q;
  logic signed [7:0]        wgt_q;
  logic signed [15:0]       bias_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic                    accept;
  logic                    req_bad;
  logic [R0_W-1:0]         r0_calc;
  logic [R0_W-1:0]         c0_calc;
  logic [POS_W-1:0]        tap_row;
  logic [POS_W-1:0]        tap_col;
  logic                    tap_ok;
  logic                    last_tap;
  logic [PIX_AW-1:0]       pix_raddr;
  logic signed [ACC_W-1:0] total;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;

  assign r0_calc = R0_W'(out_row) * R0_W'(stride);
  assign c0_calc = R0_W'(out_col) * R0_W'(stride);

  assign req_bad = (int'(fsel) >= NUM_FILTERS) ||
                   (POS_W'(r0) + POS_W'(KERNEL_DIM) >
                    POS_W'(IMG_HEIGHT) + POS_W'({padding, 1'b0})) ||
                   (POS_W'(c0) + POS_W'(KERNEL_DIM) >
                    POS_W'(IMG_WIDTH) + POS_W'({padding, 1'b0}));

  assign tap_row  = rbase + POS_W'(m_cnt);
  assign tap_col  = cbase + POS_W'(n_cnt);
  assign tap_ok   = !tap_row[POS_W-1] && (tap_row < POS_W'(IMG_HEIGHT)) &&
                    !tap_col[POS_W-1] && (tap_col < POS_W'(IMG_WIDTH));
  assign last_tap = (int'(d_cnt) == IMG_DEPTH - 1) && (int'(m_cnt) == KERNEL_DIM - 1) &&
                    (int'(n_cnt) == KERNEL_DIM - 1);
  assign pix_raddr = PIX_AW'(int'(d_cnt) * PLANE + int'(tap_row) * IMG_WIDTH + int'(tap_col));

  assign total = acc + ACC_W'(bias_q);

  // Memory writes only while idle, so reads never collide with a pending write.
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(cmd) == CMD_WR_PIX && int'(addr) < PIX_ENTRIES) begin
      pixel_mem[PIX_AW'(addr)] <= data[7:0];
    end
    if (accept && cmd_t'(cmd) == CMD_WR_WGT && int'(addr) < W_ENTRIES) begin
      weight_mem[W_AW'(addr)] <= data[7:0];
    end
    if (accept && cmd_t'(cmd) == CMD_WR_BIAS && int'(addr) < NUM_FILTERS) begin
      bias_mem[BIAS_AW'(addr)] <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN && tap_ok) begin
      pix_q <= pixel_mem[pix_raddr];
    end
    if (state == S_RUN) begin
      wgt_q <= weight_mem[w_addr];
    end
    if (state == S_CHECK && !req_bad) begin
      bias_q <= bias_mem[BIAS_AW'(fsel)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stride  <= 2'd1;
      padding <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STRIDE:  stride  <= cfg_data;
        REG_PADDING: padding <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      s1_valid <= (state == S_RUN);
      s2_valid <= s1_valid;
      unique case (state)
        S_IDLE: begin
          if (accept && cmd_t'(cmd) == CMD_COMPUTE) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (req_bad) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_tap) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd_t'(cmd) == CMD_COMPUTE) begin
      fsel <= filter_sel;
      r0   <= r0_calc;
      c0   <= c0_calc;
    end

    if (state == S_CHECK) begin
      rbase  <= POS_W'(r0) - POS_W'(padding);
      cbase  <= POS_W'(c0) - POS_W'(padding);
      d_cnt  <= '0;
      m_cnt  <= '0;
      n_cnt  <= '0;
      w_addr <= W_AW'(int'(fsel) * W_PER_FILTER);
      acc    <= '0;
    end

    // Advance the tap counters: column, then row, then depth.
    if (state == S_RUN) begin
      w_addr <= w_addr + W_AW'(1);
      if (int'(n_cnt) == KERNEL_DIM - 1) begin
        n_cnt <= '0;
        if (int'(m_cnt) == KERNEL_DIM - 1) begin
          m_cnt <= '0;
          d_cnt <= d_cnt + DC_W'(1);
        end else begin
          m_cnt <= m_cnt + KC_W'(1);
        end
      end else begin
        n_cnt <= n_cnt + KC_W'(1);
      end
    end

    s1_ok <= tap_ok;
    prod  <= (s1_valid && s1_ok) ?
             PROD_W'($signed({1'b0, pix_q})) * PROD_W'(wgt_q) : '0;
    if (s2_valid) begin
      acc <= acc + ACC_W'(prod);
    end

    if (state == S_CHECK && req_bad) begin
      pixel_out    <= 8'd0;
      out_of_range <= 1'b1;
    end else if (state == S_DRAIN && !s1_valid && !s2_valid) begin
      out_of_range <= 1'b0;
      if (total < 0) begin
        pixel_out <= 8'd0;
      end else if (total > ACC_W'(CLAMP_MAX)) begin
        pixel_out <= 8'(CLAMP_MAX);
      end else begin
        pixel_out <= total[7:0];
      end
    end
  end

endmodule

FILE: sv/conv_checker.sv
// conv_checker: port-level assertions for conv2d_relu_clamp, bound to the top level.
// Uses conv_pkg for the command codes.
module conv_checker
  import conv_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         cmd,
  input logic [11:0]        addr,
  input logic signed [15:0] data,
  input logic [1:0]         filter_sel,
  input logic [4:0]         out_row,
  input logic [4:0]         out_col,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [1:0]         cfg_index,
  input logic [1:0]         cfg_data,
  input logic               done,
  input logic [7:0]         pixel_out,
  input logic               out_of_range
);

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_COMPUTE |=> busy && !done)
    else $error("compute beat did not raise busy");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd != CMD_COMPUTE |=> !busy && !done)
    else $error("write beat changed busy or produced a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result beat without a compute in flight");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> pixel_out == 8'd0)
    else $error("out-of-range result carries nonzero pixel");

endmodule

bind conv2d_relu_clamp conv_checker u_conv_checker (.*);

FILE: sim/conv2d_predict_check.sv
// conv2d_predict_check: passive checker for conv2d_relu_clamp.
// Mirrors the stores and registers from observed beats, predicts each output pixel
// and compares it with the done strobe; depends on conv_pkg.
module conv2d_predict_check
  import conv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         cmd,
  input  logic [11:0]        addr,
  input  logic signed [15:0] data,
  input  logic [1:0]         filter_sel,
  input  logic [4:0]         out_row,
  input  logic [4:0]         out_col,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic               done,
  input  logic [7:0]         pixel_out,
  input  logic               out_of_range,
  output int                 fail_count,
  output int                 results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] pixel;
    logic       oor;
  } conv_out_t;

  logic [7:0]         image_mem  [PIX_ENTRIES];
  logic signed [7:0]  kernel_mem [W_ENTRIES];
  logic signed [15:0] bias_mem   [NUM_FILTERS];
  int                 stride_q;
  int                 pad_q;
  conv_out_t          pixels_due [$];

  function automatic conv_out_t conv_pixel(input logic [1:0] f, input logic [4:0] row,
                                           input logic [4:0] col);
    conv_out_t res;
    int        r0;
    int        c0;
    int        pr;
    int        pc;
    int        acc;
    int        p;
    int        w;
    res.pixel = '0;
    res.oor   = 1'b1;
    r0 = int'(row) * stride_q;
    c0 = int'(col) * stride_q;
    if (f >= NUM_FILTERS || r0 + KERNEL_DIM > IMG_HEIGHT + 2 * pad_q ||
        c0 + KERNEL_DIM > IMG_WIDTH + 2 * pad_q)
      return res;
    acc = 0;
    for (int d = 0; d < IMG_DEPTH; d++)
      for (int m = 0; m < KERNEL_DIM; m++)
        for (int n = 0; n < KERNEL_DIM; n++) begin
          pr = r0 + m - pad_q;
          pc = c0 + n - pad_q;
          if (pr >= 0 && pr < IMG_HEIGHT && pc >= 0 && pc < IMG_WIDTH) begin
            p = int'(image_mem[d * PLANE + pr * IMG_WIDTH + pc]);
            w = int'(kernel_mem[int'(f) * W_PER_FILTER + d * KAREA + m * KERNEL_DIM + n]);
            acc += p * w;
          end
        end
    acc += int'(bias_mem[f]);
    if (acc < 0)
      acc = 0;
    else if (acc > CLAMP_MAX)
      acc = CLAMP_MAX;
    res.pixel = acc[7:0];
    res.oor   = 1'b0;
    return res;
  endfunction

  initial begin
    fail_count  = 0;
    results_due = 0;
    stride_q    = 1;
    pad_q       = 1;
  end

  always @(posedge clk) begin : watch
    conv_out_t want;
    if (rst) begin
      stride_q = 1;
      pad_q    = 1;
      pixels_due.delete();
    end else begin
      if (done) begin
        if (pixels_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result pixel_out=%0d out_of_range=%0b",
                     $realtime, pixel_out, out_of_range);
          fail_count++;
        end else begin
          want = pixels_due.pop_front();
          if (pixel_out !== want.pixel || out_of_range !== want.oor) begin
            if (fail_count < 10)
              $display("%0t: mismatch pixel_out exp %0d got %0d, out_of_range exp %0b got %0b",
                       $realtime, want.pixel, pixel_out, want.oor, out_of_range);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        case (cmd)
          CMD_WR_PIX:  if (addr < PIX_ENTRIES) image_mem[addr] = data[7:0];
          CMD_WR_WGT:  if (addr < W_ENTRIES) kernel_mem[addr] = data[7:0];
          CMD_WR_BIAS: if (addr < NUM_FILTERS) bias_mem[addr] = data;
          CMD_COMPUTE: pixels_due.push_back(conv_pixel(filter_sel, out_row, out_col));
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STRIDE)
          stride_q = int'(cfg_data);
        else if (cfg_index == REG_PADDING)
          pad_q = int'(cfg_data);
      end
    end
    results_due = pixels_due.size();
  end

endmodule

FILE: sim/tb_conv2d_relu_clamp.sv
// tb_conv2d_relu_clamp: stimulus and verdict for conv2d_relu_clamp.
// Loads image, kernels and biases, steps through stride and padding settings and
// issues compute beats; checking is done by conv2d_predict_check. Depends on conv_pkg.
module tb_conv2d_relu_clamp;
  timeunit 1ns;
  timeprecision 1ps;
  import conv_pkg::*;

  localparam int IDLE_PCT    = 11;
  localparam int WATCHDOG    = 4000;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 8;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         cmd;
  logic [11:0]        addr;
  logic signed [15:0] data;
  logic [1:0]         filter_sel;
  logic [4:0]         out_row;
  logic [4:0]         out_col;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [1:0]         cfg_data;
  logic               done;
  logic [7:0]         pixel_out;
  logic               out_of_range;
  int                 fail_count;
  int                 results_due;

  bit pix_loaded  [PIX_ENTRIES];
  bit filt_loaded [NUM_FILTERS];
  int cur_stride;
  int cur_pad;
  int n_items;
  bit no_gaps;
  int silent_cycles;
  int ph_stride [NUM_PHASES] = '{1, 2, 3, 0, 1, 3, 2, 1};
  int ph_pad    [NUM_PHASES] = '{1, 0, 2, 3, 0, 3, 2, 2};

  conv2d_relu_clamp dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .addr         (addr),
    .data         (data),
    .filter_sel   (filter_sel),
    .out_row      (out_row),
    .out_col      (out_col),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .pixel_out    (pixel_out),
    .out_of_range (out_of_range)
  );

  conv2d_predict_check checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .addr         (addr),
    .data         (data),
    .filter_sel   (filter_sel),
    .out_row      (out_row),
    .out_col      (out_col),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .pixel_out    (pixel_out),
    .out_of_range (out_of_range),
    .fail_count   (fail_count),
    .results_due  (results_due)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial silent_cycles = 0;

  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || done)
      silent_cycles <= 0;
    else
      silent_cycles <= silent_cycles + 1;
    if (silent_cycles == WATCHDOG) begin
      $display("tb_conv2d_relu_clamp: errors");
      $finish;
    end
  end

  function automatic logic [15:0] pixel_word();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(1) == 1)
      w[7:0] = 8'($urandom_range(15));
    return w;
  endfunction

  function automatic bit fits(input int row, input int col);
    return row * cur_stride + KERNEL_DIM <= IMG_HEIGHT + 2 * cur_pad &&
           col * cur_stride + KERNEL_DIM <= IMG_WIDTH + 2 * cur_pad;
  endfunction

  function automatic int max_pos(input int extent);
    int lim;
    if (cur_stride == 0)
      return 31;
    lim = (extent + 2 * cur_pad - KERNEL_DIM) / cur_stride;
    return (lim > 31) ? 31 : lim;
  endfunction

  // hold start high across back-to-back beats; drop it only for random idle cycles
  task automatic send_beat(input cmd_t c, input logic [11:0] a, input logic [15:0] d,
                           input logic [1:0] f, input logic [4:0] row, input logic [4:0] col);
    bit taken;
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      start = 1'b0;
      @(negedge clk);
    end
    start      = 1'b1;
    cmd        = c;
    addr       = a;
    data       = d;
    filter_sel = f;
    out_row    = row;
    out_col    = col;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
    if (!((c == CMD_WR_PIX && a >= PIX_ENTRIES) || (c == CMD_WR_WGT && a >= W_ENTRIES) ||
          (c == CMD_WR_BIAS && a >= NUM_FILTERS)))
      n_items++;
  endtask

  task automatic write_item(input cmd_t c, input int a, input logic [15:0] d);
    send_beat(c, 12'(a), d, 2'($urandom), 5'($urandom), 5'($urandom));
    if (c == CMD_WR_PIX && a < PIX_ENTRIES)
      pix_loaded[a] = 1'b1;
  endtask

  task automatic load_filter(input int f);
    bit          gentle;
    logic [15:0] d;
    gentle = 1'($urandom_range(1));
    for (int i = 0; i < W_PER_FILTER; i++) begin
      d = 16'($urandom);
      if (gentle)
        d[7:0] = 8'($urandom_range(3) - 1);
      write_item(CMD_WR_WGT, f * W_PER_FILTER + i, d);
    end
    d = 16'($urandom);
    if (gentle)
      d = 16'($urandom_range(400) - 250);
    write_item(CMD_WR_BIAS, f, d);
    filt_loaded[f] = 1'b1;
  endtask

  task automatic fill_window(input int f, input int row, input int col);
    int pr;
    int pc;
    int a;
    if (!filt_loaded[f])
      load_filter(f);
    for (int d = 0; d < IMG_DEPTH; d++)
      for (int m = 0; m < KERNEL_DIM; m++)
        for (int n = 0; n < KERNEL_DIM; n++) begin
          pr = row * cur_stride + m - cur_pad;
          pc = col * cur_stride + n - cur_pad;
          if (pr >= 0 && pr < IMG_HEIGHT && pc >= 0 && pc < IMG_WIDTH) begin
            a = d * PLANE + pr * IMG_WIDTH + pc;
            if (!pix_loaded[a])
              write_item(CMD_WR_PIX, a, pixel_word());
          end
        end
  endtask

  task automatic compute_at(input int f, input int row, input int col);
    if (f < NUM_FILTERS && fits(row, col))
      fill_window(f, row, col);
    send_beat(CMD_COMPUTE, 12'($urandom), 16'($urandom), 2'(f), 5'(row), 5'(col));
  endtask

  task automatic drain();
    start = 1'b0;
    while (results_due != 0)
      @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [1:0] val);
    bit taken;
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do begin
      taken = cfg_ready;
      @(negedge clk);
    end while (!taken);
    cfg_valid = 1'b0;
    if (idx == REG_STRIDE)
      cur_stride = int'(val);
    else if (idx == REG_PADDING)
      cur_pad = int'(val);
  endtask

  task automatic run_phase(input int budget);
    int goal;
    int mr;
    int mc;
    int f;
    int row;
    int col;
    int pick;
    goal = n_items + budget;
    compute_at(0, 0, 0);
    compute_at(1, max_pos(IMG_HEIGHT), max_pos(IMG_WIDTH));
    compute_at(2, 31, 31);
    while (n_items < goal) begin
      mr   = max_pos(IMG_HEIGHT);
      mc   = max_pos(IMG_WIDTH);
      pick = $urandom_range(99);
      if (pick < 60) begin
        f = ($urandom_range(19) == 0) ? 3 : $urandom_range(NUM_FILTERS - 1);
        if ($urandom_range(4) == 0) begin
          row = $urandom_range(31);
          col = $urandom_range(31);
        end else if ($urandom_range(1) == 1) begin
          row = $urandom_range((mr < 3) ? mr : 3);
          col = $urandom_range((mc < 3) ? mc : 3);
        end else begin
          row = $urandom_range(mr);
          col = $urandom_range(mc);
        end
        compute_at(f, row, col);
      end else if (pick < 78) begin
        write_item(CMD_WR_PIX, $urandom_range(4095), pixel_word());
      end else if (pick < 88) begin
        write_item(CMD_WR_WGT, $urandom_range(127), 16'($urandom));
      end else if (pick < 93) begin
        write_item(CMD_WR_BIAS, $urandom_range(3), 16'($urandom));
      end else if (pick < 98) begin
        load_filter($urandom_range(NUM_FILTERS - 1));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_WR_PIX;
    addr       = '0;
    data       = '0;
    filter_sel = '0;
    out_row    = '0;
    out_col    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_STRIDE;
    cfg_data   = '0;
    cur_stride = 1;
    cur_pad    = 1;
    n_items    = 0;
    no_gaps    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_item(CMD_WR_PIX, PIX_ENTRIES, 16'hFFFF);
    write_item(CMD_WR_WGT, 4095, 16'h7FFF);
    write_item(CMD_WR_BIAS, NUM_FILTERS, 16'h8000);
    write_item(CMD_WR_PIX, 0, 16'h7FFF);
    write_item(CMD_WR_PIX, PIX_ENTRIES - 1, 16'h8000);
    send_beat(CMD_COMPUTE, 12'hFFF, 16'hFFFF, 2'd3, 5'd31, 5'd31);
    send_beat(CMD_COMPUTE, 12'h000, 16'h0000, 2'd3, 5'd0, 5'd0);
    load_filter(0);
    write_item(CMD_WR_BIAS, 0, 16'h7FFF);
    compute_at(0, 0, 0);
    write_item(CMD_WR_BIAS, 0, 16'h8000);
    compute_at(0, 31, 31);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        set_reg(REG_STRIDE, 2'(ph_stride[ph]));
        set_reg(REG_PADDING, 2'(ph_pad[ph]));
      end
      if (ph == 3) begin
        set_reg(REG_SPARE_A, 2'd3);
        set_reg(REG_SPARE_B, 2'd2);
      end
      no_gaps = (ph == 4);
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("tb_conv2d_relu_clamp: clean");
    else
      $display("tb_conv2d_relu_clamp: errors");
    $finish;
  end

endmodule
